// File: sv/wpm_pkg.sv
package wpm_pkg;

    localparam int PAT_DEPTH  = 64;
    localparam int SUBJ_DEPTH = 256;
    localparam int CHAR_W     = 8;

    localparam int PA_W   = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int SA_W   = (SUBJ_DEPTH > 1) ? $clog2(SUBJ_DEPTH) : 1;
    localparam int PCNT_W = $clog2(PAT_DEPTH + 1);
    localparam int SCNT_W = $clog2(SUBJ_DEPTH + 1);

    localparam logic [1:0] OP_PAT_CHAR  = 2'd0;
    localparam logic [1:0] OP_SUBJ_CHAR = 2'd1;
    localparam logic [1:0] OP_EVAL      = 2'd2;
    localparam logic [1:0] OP_CLEAR_PAT = 2'd3;

    localparam logic [CHAR_W-1:0] STAR_CODE  = 8'd42;
    localparam logic [CHAR_W-1:0] WILD_RESET = 8'd63;

    typedef struct packed {
        logic              start;
        logic [PCNT_W-1:0] plen;
        logic [SCNT_W-1:0] slen;
        logic [CHAR_W-1:0] wild;
    } t_walk_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_walk_rsp;

endpackage

// File: sv/wpm_ifs.sv
interface wpm_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [wpm_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink (input valid, input matched, input overflow, output ready);
endinterface

interface wpm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [wpm_pkg::CHAR_W-1:0] single_char_wildcard;

    modport source (output valid, output single_char_wildcard, input ready);
    modport sink (input valid, input single_char_wildcard, output ready);
endinterface

// File: sv/wpm_ram.sv
module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/wpm_walk.sv
module wpm_walk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wpm_pkg::t_walk_req                  i_req,
    input  logic [wpm_pkg::CHAR_W-1:0]          i_pat_data,
    input  logic [wpm_pkg::CHAR_W-1:0]          i_subj_data,
    output logic [wpm_pkg::PA_W-1:0]            o_pat_addr,
    output logic [wpm_pkg::SA_W-1:0]            o_subj_addr,
    output wpm_pkg::t_walk_rsp                  o_rsp
);
    import wpm_pkg::*;

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_RD   = 3'd1;
    localparam logic [2:0] W_EV   = 3'd2;
    localparam logic [2:0] W_TRD  = 3'd3;
    localparam logic [2:0] W_TEV  = 3'd4;

    logic [2:0]        r_state;
    logic [PCNT_W-1:0] r_wi;
    logic [PCNT_W-1:0] r_bw;
    logic [SCNT_W-1:0] r_si;
    logic [SCNT_W:0]   r_bs;
    logic              r_seen;
    logic [PCNT_W-1:0] r_plen;
    logic [SCNT_W-1:0] r_slen;
    logic [CHAR_W-1:0] r_wild;
    logic              r_done;
    logic              r_hit;

    logic [PCNT_W-1:0] wi_inc;
    logic [SCNT_W-1:0] si_inc;
    logic              pat_in;
    logic              is_star;
    logic              char_ok;
    logic              walk_end;

    assign wi_inc  = r_wi + PCNT_W'(1);
    assign si_inc  = r_si + SCNT_W'(1);
    assign pat_in  = (r_wi != r_plen);
    assign is_star = (i_pat_data == STAR_CODE);
    assign char_ok = (i_pat_data == i_subj_data) || (i_pat_data == r_wild);

    assign walk_end = ((r_state == W_EV) &&
                       ((pat_in && is_star && (wi_inc == r_plen)) ||
                        (!(pat_in && is_star) && !(pat_in && char_ok) && !r_seen))) ||
                      ((r_state == W_TRD) && !pat_in) ||
                      ((r_state == W_TEV) && !is_star);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_done <= walk_end;
            case (r_state)
                W_IDLE: begin
                    if (i_req.start) begin
                        r_wi   <= '0;
                        r_si   <= '0;
                        r_bw   <= '0;
                        r_bs   <= '0;
                        r_seen <= 1'b0;
                        r_plen <= i_req.plen;
                        r_slen <= i_req.slen;
                        r_wild <= i_req.wild;
                        r_state <= (i_req.slen == '0) ? W_TRD : W_RD;
                    end
                end
                W_RD: begin
                    r_state <= W_EV;
                end
                W_EV: begin
                    if (pat_in && is_star) begin
                        r_wi <= wi_inc;
                        if (wi_inc == r_plen) begin
                            r_hit   <= 1'b1;
                            r_state <= W_IDLE;
                        end else begin
                            r_bw    <= wi_inc;
                            r_bs    <= {1'b0, si_inc};
                            r_seen  <= 1'b1;
                            r_state <= W_RD;
                        end
                    end else if (pat_in && char_ok) begin
                        r_wi    <= wi_inc;
                        r_si    <= si_inc;
                        r_state <= (si_inc == r_slen) ? W_TRD : W_RD;
                    end else if (!r_seen) begin
                        r_hit   <= 1'b0;
                        r_state <= W_IDLE;
                    end else begin
                        r_wi    <= r_bw;
                        r_si    <= r_bs[SCNT_W-1:0];
                        r_bs    <= r_bs + (SCNT_W + 1)'(1);
                        r_state <= (r_bs == {1'b0, r_slen}) ? W_TRD : W_RD;
                    end
                end
                W_TRD: begin
                    if (!pat_in) begin
                        r_hit   <= 1'b1;
                        r_state <= W_IDLE;
                    end else begin
                        r_state <= W_TEV;
                    end
                end
                W_TEV: begin
                    if (is_star) begin
                        r_wi    <= wi_inc;
                        r_state <= W_TRD;
                    end else begin
                        r_hit   <= 1'b0;
                        r_state <= W_IDLE;
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_pat_addr  = r_wi[PA_W-1:0];
    assign o_subj_addr = r_si[SA_W-1:0];
    assign o_rsp.done  = r_done;
    assign o_rsp.hit   = r_hit;

endmodule

// File: sv/wildcard_pattern_matcher_top.sv
// Glob matcher with '*' and a programmable single-character wildcard (reset '?').
// Pattern characters (opcode 0), subject characters (opcode 1) and a pattern
// clear (opcode 3) give no result. An evaluate word (opcode 2) walks the
// pattern and subject memories; each walk step first reads both memories,
// whose read data is registered, and then evaluates the characters. An
// overflowed buffer skips the walk and reports overflow with no match. Input is
// held off during the walk; the result sits in an output register, so the next
// word is taken while it waits. The subject is cleared after every evaluation.
module wildcard_pattern_matcher_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wpm_in_if.sink    i_item,
    wpm_cfg_if.sink   i_cfg,
    wpm_out_if.source o_res
);
    import wpm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        r_state;
    logic [PCNT_W-1:0] r_plen;
    logic [SCNT_W-1:0] r_slen;
    logic              r_povf;
    logic              r_sovf;
    logic [CHAR_W-1:0] r_wild;
    logic              r_start;
    logic              r_hit;
    logic              r_ovf;
    logic              r_out_valid;
    logic              r_out_matched;
    logic              r_out_overflow;

    logic              accept;
    logic              pat_we;
    logic              subj_we;
    logic              load_out;
    logic [PA_W-1:0]   pat_raddr;
    logic [SA_W-1:0]   subj_raddr;
    logic [CHAR_W-1:0] pat_rdata;
    logic [CHAR_W-1:0] subj_rdata;
    t_walk_req         walk_req;
    t_walk_rsp         walk_rsp;

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign pat_we       = accept && (i_item.opcode == OP_PAT_CHAR) &&
                          (r_plen < PCNT_W'(PAT_DEPTH));
    assign subj_we      = accept && (i_item.opcode == OP_SUBJ_CHAR) &&
                          (r_slen < SCNT_W'(SUBJ_DEPTH));
    assign load_out     = (r_state == ST_HOLD) && (!r_out_valid || o_res.ready);
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_plen      <= '0;
            r_slen      <= '0;
            r_povf      <= 1'b0;
            r_sovf      <= 1'b0;
            r_wild      <= WILD_RESET;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept && (i_item.opcode == OP_EVAL) && !(r_povf || r_sovf);
            if (i_cfg.valid) begin
                r_wild <= i_cfg.single_char_wildcard;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_item.opcode)
                            OP_PAT_CHAR: begin
                                if (pat_we) begin
                                    r_plen <= r_plen + PCNT_W'(1);
                                end else begin
                                    r_povf <= 1'b1;
                                end
                            end
                            OP_SUBJ_CHAR: begin
                                if (subj_we) begin
                                    r_slen <= r_slen + SCNT_W'(1);
                                end else begin
                                    r_sovf <= 1'b1;
                                end
                            end
                            OP_EVAL: begin
                                if (r_povf || r_sovf) begin
                                    r_hit   <= 1'b0;
                                    r_ovf   <= 1'b1;
                                    r_state <= ST_HOLD;
                                end else begin
                                    r_ovf   <= 1'b0;
                                    r_state <= ST_WALK;
                                end
                            end
                            OP_CLEAR_PAT: begin
                                r_plen <= '0;
                                r_povf <= 1'b0;
                            end
                            default: begin
                                r_povf <= r_povf;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (walk_rsp.done) begin
                        r_hit   <= walk_rsp.hit;
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (load_out) begin
                        r_slen      <= '0;
                        r_sovf      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_matched  <= r_hit;
            r_out_overflow <= r_ovf;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.matched  = r_out_matched;
    assign o_res.overflow = r_out_overflow;

    assign walk_req.start = r_start;
    assign walk_req.plen  = r_plen;
    assign walk_req.slen  = r_slen;
    assign walk_req.wild  = r_wild;

    wpm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (PAT_DEPTH)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_plen[PA_W-1:0]),
        .i_wdata (i_item.char_code),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    wpm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (SUBJ_DEPTH)
    ) u_subj_ram (
        .i_clk   (i_clk),
        .i_we    (subj_we),
        .i_waddr (r_slen[SA_W-1:0]),
        .i_wdata (i_item.char_code),
        .i_raddr (subj_raddr),
        .o_rdata (subj_rdata)
    );

    wpm_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (walk_req),
        .i_pat_data  (pat_rdata),
        .i_subj_data (subj_rdata),
        .o_pat_addr  (pat_raddr),
        .o_subj_addr (subj_raddr),
        .o_rsp       (walk_rsp)
    );

endmodule

// File: sv/wpm_checker.sv
module wpm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_opcode,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_matched,
    input logic       i_out_overflow
);
    import wpm_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result word is valid right after reset.");

    a_eval_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_opcode == OP_EVAL)) |=> !i_in_ready)
        else $error("Input was ready in the cycle after an evaluate word.");

    a_overflow_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_matched && i_out_overflow))
        else $error("Result word reports a match together with overflow.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_matched) && $stable(i_out_overflow)))
        else $error("Stalled result word changed or was dropped.");

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_in_opcode    (i_item.opcode),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_matched  (o_res.matched),
    .i_out_overflow (o_res.overflow)
);
